// File: design/spom_pkg.sv
// ----------------------------------------------------------------------------
// Spiral matrix reader package
// Shared constants, register indexes, operation codes and control types.
// ----------------------------------------------------------------------------
`default_nettype none

package spom_pkg;

  // Configuration register layout.
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;

  localparam logic [CFG_W-1:0] ROW_COUNT_RESET    = 7'd4;
  localparam logic [CFG_W-1:0] COLUMN_COUNT_RESET = 7'd5;

  // Width of the row and column fields of a result item.
  localparam int IDX_OUT_W = 6;

  // Operation codes of an input item.
  localparam logic OP_STORE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Leg of the spiral that is being walked.
  typedef enum logic [3:0] {
    DIR_RIGHT = 4'b0001,
    DIR_DOWN  = 4'b0010,
    DIR_LEFT  = 4'b0100,
    DIR_UP    = 4'b1000
  } dir_t;

  // Commands from the top level to the position walker.
  typedef struct packed {
    logic restart;
    logic wr_step;
    logic rd_step;
  } walk_ctl_t;

endpackage

`default_nettype wire

// File: design/spom_if.sv
// ----------------------------------------------------------------------------
// Spiral matrix reader channels
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface spom_in_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic signed [DATA_WIDTH-1:0] element_value;

  modport source (output valid, output operation, output element_value, input ready);
  modport sink   (input valid, input operation, input element_value, output ready);
endinterface

interface spom_out_if #(parameter int DATA_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [DATA_WIDTH-1:0]  read_value;
  logic [spom_pkg::IDX_OUT_W-1:0] row_index;
  logic [spom_pkg::IDX_OUT_W-1:0] column_index;
  logic                          last_cell;

  modport source (output valid, output read_value, output row_index,
                  output column_index, output last_cell, input ready);
  modport sink   (input valid, input read_value, input row_index,
                  input column_index, input last_cell, output ready);
endinterface

interface spom_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [spom_pkg::CFG_IDX_W-1:0]  index;
  logic [spom_pkg::CFG_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/spom_store.sv
// ----------------------------------------------------------------------------
// Spiral matrix element store
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module spom_store #(
  parameter int ADDR_W     = 12,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [ADDR_W-1:0]     waddr,
  input  wire logic [DATA_WIDTH-1:0] wdata,
  input  wire logic                  re,
  input  wire logic [ADDR_W-1:0]     raddr,
  output logic      [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [2**ADDR_W];
  logic [DATA_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: design/spom_walker.sv
// ----------------------------------------------------------------------------
// Spiral matrix position walker
// Keeps the row-major write position and the clockwise spiral position.
// ----------------------------------------------------------------------------
`default_nettype none

module spom_walker import spom_pkg::*; #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire walk_ctl_t  ctl,
  input  wire logic [$clog2(MAX_ROWS+1)-1:0]    rows,
  input  wire logic [$clog2(MAX_COLUMNS+1)-1:0] cols,
  output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0]       wr_row,
  output logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] wr_col,
  output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0]       sp_row,
  output logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] sp_col,
  output logic last
);

  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNR = $clog2(MAX_ROWS + 1);
  localparam int CNC = $clog2(MAX_COLUMNS + 1);
  localparam int TW  = $clog2(MAX_ROWS * MAX_COLUMNS + 1);

  logic [RW-1:0] wr_row_r, wr_row_nxt;
  logic [CW-1:0] wr_col_r, wr_col_nxt;
  logic [RW-1:0] sp_row_r, sp_row_nxt;
  logic [CW-1:0] sp_col_r, sp_col_nxt;
  dir_t          dir_r, dir_nxt;
  // Bounds are kept as distances from the outer edge so reset needs no counts.
  logic [RW-1:0] top_r, top_nxt;
  logic [RW-1:0] bot_trim_r, bot_trim_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic [CW-1:0] right_trim_r, right_trim_nxt;
  logic [TW-1:0] emitted_r, emitted_nxt;

  logic [RW-1:0] row_last;
  logic [CW-1:0] col_last;
  logic [RW-1:0] bottom;
  logic [CW-1:0] right;
  logic [TW-1:0] total;

  assign row_last = RW'(rows - CNR'(1));
  assign col_last = CW'(cols - CNC'(1));
  assign bottom   = row_last - bot_trim_r;
  assign right    = col_last - right_trim_r;
  assign total    = TW'(rows) * TW'(cols);
  assign last     = (emitted_r + TW'(1)) == total;

  always_comb begin
    wr_row_nxt     = wr_row_r;
    wr_col_nxt     = wr_col_r;
    sp_row_nxt     = sp_row_r;
    sp_col_nxt     = sp_col_r;
    dir_nxt        = dir_r;
    top_nxt        = top_r;
    bot_trim_nxt   = bot_trim_r;
    left_nxt       = left_r;
    right_trim_nxt = right_trim_r;
    emitted_nxt    = emitted_r;

    if (ctl.wr_step) begin
      if (wr_col_r == col_last) begin
        wr_col_nxt = '0;
        wr_row_nxt = (wr_row_r == row_last) ? '0 : wr_row_r + RW'(1);
      end else begin
        wr_col_nxt = wr_col_r + CW'(1);
      end
    end

    if (ctl.rd_step) begin
      if (last) begin
        sp_row_nxt     = '0;
        sp_col_nxt     = '0;
        dir_nxt        = DIR_RIGHT;
        top_nxt        = '0;
        bot_trim_nxt   = '0;
        left_nxt       = '0;
        right_trim_nxt = '0;
        emitted_nxt    = '0;
      end else begin
        emitted_nxt = emitted_r + TW'(1);
        case (dir_r)
          DIR_RIGHT: begin
            if (sp_col_r < right) begin
              sp_col_nxt = sp_col_r + CW'(1);
            end else begin
              top_nxt    = top_r + RW'(1);
              dir_nxt    = DIR_DOWN;
              sp_row_nxt = sp_row_r + RW'(1);
            end
          end
          DIR_DOWN: begin
            if (sp_row_r < bottom) begin
              sp_row_nxt = sp_row_r + RW'(1);
            end else begin
              right_trim_nxt = right_trim_r + CW'(1);
              dir_nxt        = DIR_LEFT;
              sp_col_nxt     = sp_col_r - CW'(1);
            end
          end
          DIR_LEFT: begin
            if (sp_col_r > left_r) begin
              sp_col_nxt = sp_col_r - CW'(1);
            end else begin
              bot_trim_nxt = bot_trim_r + RW'(1);
              dir_nxt      = DIR_UP;
              sp_row_nxt   = sp_row_r - RW'(1);
            end
          end
          DIR_UP: begin
            if (sp_row_r > top_r) begin
              sp_row_nxt = sp_row_r - RW'(1);
            end else begin
              left_nxt   = left_r + CW'(1);
              dir_nxt    = DIR_RIGHT;
              sp_col_nxt = sp_col_r + CW'(1);
            end
          end
          default: begin
            dir_nxt = DIR_RIGHT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.restart) begin
      wr_row_r     <= '0;
      wr_col_r     <= '0;
      sp_row_r     <= '0;
      sp_col_r     <= '0;
      dir_r        <= DIR_RIGHT;
      top_r        <= '0;
      bot_trim_r   <= '0;
      left_r       <= '0;
      right_trim_r <= '0;
      emitted_r    <= '0;
    end else begin
      wr_row_r     <= wr_row_nxt;
      wr_col_r     <= wr_col_nxt;
      sp_row_r     <= sp_row_nxt;
      sp_col_r     <= sp_col_nxt;
      dir_r        <= dir_nxt;
      top_r        <= top_nxt;
      bot_trim_r   <= bot_trim_nxt;
      left_r       <= left_nxt;
      right_trim_r <= right_trim_nxt;
      emitted_r    <= emitted_nxt;
    end
  end

  assign wr_row = wr_row_r;
  assign wr_col = wr_col_r;
  assign sp_row = sp_row_r;
  assign sp_col = sp_col_r;

endmodule

`default_nettype wire

// File: design/spiral_order_matrix_reader.sv
// ----------------------------------------------------------------------------
// Spiral order matrix reader
// Stores a matrix row-major and returns its elements in clockwise spiral order.
// ----------------------------------------------------------------------------
//  Channel   Dir  Fields                                          Accepted when
//  in_ch     in   operation, element_value                        valid & ready
//  out_ch    out  read_value, row_index, column_index, last_cell  valid & ready
//  cfg_ch    in   index, data                                     valid & ready
//
//  A read item fetches its element from a memory with a registered read port,
//  so no new item is accepted while a read is in flight. The result register
//  frees in the cycle it is taken, so a new item can be accepted then. Reset
//  is synchronous, clears the positions and sets the counts to 4 rows by 5
//  columns; the memory is not cleared. A register write always completes;
//  a write to the row or column count restarts both positions.
// ----------------------------------------------------------------------------
`default_nettype none

module spiral_order_matrix_reader import spom_pkg::*; #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64,
  parameter int DATA_WIDTH  = 32
) (
  input wire logic    clk,
  input wire logic    rst_n,
  spom_in_if.sink     in_ch,
  spom_out_if.source  out_ch,
  spom_cfg_if.sink    cfg_ch
);

  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNR = $clog2(MAX_ROWS + 1);
  localparam int CNC = $clog2(MAX_COLUMNS + 1);
  localparam int EXT = 9;

  logic [CFG_W-1:0] row_count_r;
  logic [CFG_W-1:0] column_count_r;
  logic             pend_r;
  logic             out_valid_r;
  logic [RW-1:0]    row_r;
  logic [CW-1:0]    col_r;
  logic             last_r;

  logic [EXT-1:0]   rows_ext;
  logic [EXT-1:0]   cols_ext;
  logic [CNR-1:0]   rows;
  logic [CNC-1:0]   cols;
  logic             in_acc;
  logic             rd_fire;
  logic             cfg_acc;
  walk_ctl_t        ctl;
  logic [RW-1:0]    wr_row;
  logic [CW-1:0]    wr_col;
  logic [RW-1:0]    sp_row;
  logic [CW-1:0]    sp_col;
  logic             last;
  logic [DATA_WIDTH-1:0] rdata;

  // A count of zero is taken as one; counts above the maximum saturate.
  assign rows_ext = {{(EXT-CFG_W){1'b0}}, row_count_r};
  assign cols_ext = {{(EXT-CFG_W){1'b0}}, column_count_r};
  assign rows = (rows_ext == '0) ? CNR'(1) :
                (rows_ext > EXT'(MAX_ROWS)) ? CNR'(MAX_ROWS) : CNR'(rows_ext);
  assign cols = (cols_ext == '0) ? CNC'(1) :
                (cols_ext > EXT'(MAX_COLUMNS)) ? CNC'(MAX_COLUMNS) : CNC'(cols_ext);

  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid;

  assign in_ch.ready = !pend_r && (!out_valid_r || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign rd_fire     = in_acc && (in_ch.operation == OP_READ);

  always_comb begin
    ctl.restart = cfg_acc && ((cfg_ch.index == REG_ROW_COUNT) ||
                              (cfg_ch.index == REG_COLUMN_COUNT));
    ctl.wr_step = in_acc && (in_ch.operation == OP_STORE);
    ctl.rd_step = rd_fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= ROW_COUNT_RESET;
      column_count_r <= COLUMN_COUNT_RESET;
    end else if (cfg_acc) begin
      case (cfg_ch.index)
        REG_ROW_COUNT:    row_count_r    <= cfg_ch.data;
        REG_COLUMN_COUNT: column_count_r <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  spom_walker #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_walker (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .rows   (rows),
    .cols   (cols),
    .wr_row (wr_row),
    .wr_col (wr_col),
    .sp_row (sp_row),
    .sp_col (sp_col),
    .last   (last)
  );

  spom_store #(
    .ADDR_W     (RW + CW),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (ctl.wr_step),
    .waddr ({wr_row, wr_col}),
    .wdata (in_ch.element_value),
    .re    (rd_fire),
    .raddr ({sp_row, sp_col}),
    .rdata (rdata)
  );

  // The read is in flight while pend_r is set; the result register is free by then.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= rd_fire;
      if (pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_fire) begin
      row_r  <= sp_row;
      col_r  <= sp_col;
      last_r <= last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_value   = rdata;
  assign out_ch.row_index    = IDX_OUT_W'(row_r);
  assign out_ch.column_index = IDX_OUT_W'(col_r);
  assign out_ch.last_cell    = last_r;

endmodule

`default_nettype wire
